// ===== sv/dtf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtf_pkg
// Shared types and constants of the dirty tracked framebuffer: screen
// geometry, derived widths, command codes and the control/status bundles.
// ----------------------------------------------------------------------------
package dtf_pkg;

	// screen geometry
	localparam int SCREEN_WIDTH  = 64;
	localparam int SCREEN_HEIGHT = 64;
	localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;

	// field widths
	localparam int POS_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int COLOR_W = 16;

	// upper bound on any column or row a rectangle walk can reach
	localparam int MAX_COORD = (2 ** POS_W - 1) + (2 ** SIZE_W - 1);
	localparam int COL_W     = $clog2(MAX_COORD + 1);
	// linear offset wide enough for any walk position, before range check
	localparam int OFF_W     = $clog2(MAX_COORD * (SCREEN_WIDTH + 1) + 1);
	localparam int ADDR_W    = $clog2(PIXEL_COUNT);

	typedef enum logic [1:0] {
		CMD_POINT = 2'd0,
		CMD_FILL  = 2'd1,
		CMD_FLUSH = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	// controller to datapath commands
	typedef struct packed {
		logic clear;     // clearing pass, one entry per cycle
		logic load;      // input beat accepted, capture fields
		logic point;     // single pixel write or read issue
		logic step;      // one rectangle pixel
		logic out_load;  // capture result into output register
	} dtf_ctl_t;

	// datapath to controller status
	typedef struct packed {
		logic clear_last;
		logic walk_last;
	} dtf_stat_t;

endpackage

// ===== sv/dtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// dtf_ctrl
// Controller of the framebuffer: clearing pass after reset, command
// sequencing, rectangle walk control and output beat handshake.
// ----------------------------------------------------------------------------
module dtf_ctrl
	import dtf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  cmd_t      cmd,
	input  logic      out_ready,
	output logic      out_valid,
	input  dtf_stat_t stat,
	output dtf_ctl_t  ctl
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_POINT = 6'b000100,
		ST_WALK  = 6'b001000,
		ST_DRAIN = 6'b010000,
		ST_DONE  = 6'b100000
	} dtf_state_t;

	dtf_state_t state_q;
	dtf_state_t state_nxt;
	logic       out_valid_q;

	// next state and commands
	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		in_ready  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctl.clear = 1'b1;
				if (stat.clear_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctl.load = 1'b1;
					if (cmd == CMD_FILL || cmd == CMD_FLUSH) begin
						state_nxt = ST_WALK;
					end else begin
						state_nxt = ST_POINT;
					end
				end
			end
			ST_POINT: begin
				ctl.point = 1'b1;
				state_nxt = ST_DONE;
			end
			ST_WALK: begin
				ctl.step = 1'b1;
				if (stat.walk_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			// lets the last flush write-back complete
			ST_DRAIN: begin
				state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/dtf_datapath.sv =====
// ----------------------------------------------------------------------------
// dtf_datapath
// Datapath of the framebuffer: shadow, dirty and displayed stores, the
// rectangle walker, the flush read/write-back pipe and the result register.
// ----------------------------------------------------------------------------
module dtf_datapath
	import dtf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  dtf_ctl_t           ctl,
	output dtf_stat_t          stat,
	input  cmd_t               cmd,
	input  logic [POS_W-1:0]   pos_x,
	input  logic [POS_W-1:0]   pos_y,
	input  logic [SIZE_W-1:0]  rect_width,
	input  logic [SIZE_W-1:0]  rect_height,
	input  logic [COLOR_W-1:0] color,
	output logic [COLOR_W-1:0] pixel_value,
	output logic               pixel_dirty,
	output logic               status
);

	// stores
	logic [COLOR_W-1:0] shadow_mem [PIXEL_COUNT];
	logic               dirty_mem  [PIXEL_COUNT];
	logic [COLOR_W-1:0] shown_mem  [PIXEL_COUNT];

	// captured command
	cmd_t               cmd_q;
	logic [POS_W-1:0]   x_q;
	logic [POS_W-1:0]   y_q;
	logic [SIZE_W-1:0]  w_q;
	logic [SIZE_W-1:0]  h_q;
	logic [COLOR_W-1:0] color_q;

	// walker and clearing counters
	logic [SIZE_W-1:0]  c_q;
	logic [SIZE_W-1:0]  r_q;
	logic [ADDR_W-1:0]  clr_q;

	// registered read data
	logic [COLOR_W-1:0] shadow_rd_q;
	logic               dirty_rd_q;
	logic [COLOR_W-1:0] shown_rd_q;

	// flush pipe
	logic               flush_vld_s1;
	logic [ADDR_W-1:0]  flush_addr_s1;
	logic               wb_vld_s2;
	logic [ADDR_W-1:0]  wb_addr_s2;

	// result register
	logic [COLOR_W-1:0] pixel_value_q;
	logic               pixel_dirty_q;
	logic               status_q;

	logic [OFF_W-1:0]   pt_off;
	logic               pt_in_range;
	logic [COL_W-1:0]   walk_col;
	logic [COL_W-1:0]   walk_row;
	logic [OFF_W-1:0]   walk_off;
	logic               rect_empty;
	logic               pix_ok;
	logic [ADDR_W-1:0]  rd_addr;
	logic               dirty_eff;
	logic               wb_en;

	logic               shadow_we;
	logic [ADDR_W-1:0]  shadow_wa;
	logic               dirty_we;
	logic [ADDR_W-1:0]  dirty_wa;
	logic               dirty_wd;
	logic               shown_we;
	logic [ADDR_W-1:0]  shown_wa;
	logic [COLOR_W-1:0] shown_wd;

	// point offset and range
	assign pt_off      = OFF_W'(x_q) + OFF_W'(y_q) * OFF_W'(SCREEN_WIDTH);
	assign pt_in_range = pt_off < OFF_W'(PIXEL_COUNT);

	// rectangle walk position
	assign walk_col   = COL_W'(x_q) + COL_W'(c_q);
	assign walk_row   = COL_W'(y_q) + COL_W'(r_q);
	assign walk_off   = OFF_W'(walk_col) + OFF_W'(walk_row) * OFF_W'(SCREEN_WIDTH);
	assign rect_empty = (w_q == '0) || (h_q == '0);
	assign pix_ok     = !rect_empty && (walk_off < OFF_W'(PIXEL_COUNT));

	assign stat.walk_last  = rect_empty ||
		((c_q == w_q - SIZE_W'(1)) && (r_q == h_q - SIZE_W'(1)));
	assign stat.clear_last = clr_q == ADDR_W'(PIXEL_COUNT - 1);

	// capture input beat
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q   <= cmd;
			x_q     <= pos_x;
			y_q     <= pos_y;
			w_q     <= rect_width;
			h_q     <= rect_height;
			color_q <= color;
		end
	end

	// walker counters, row by row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (ctl.load) begin
			c_q <= '0;
			r_q <= '0;
		end else if (ctl.step) begin
			if (c_q == w_q - SIZE_W'(1)) begin
				c_q <= '0;
				r_q <= r_q + SIZE_W'(1);
			end else begin
				c_q <= c_q + SIZE_W'(1);
			end
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (ctl.clear) begin
			clr_q <= clr_q + ADDR_W'(1);
		end
	end

	// shared read address
	assign rd_addr = ctl.step ? walk_off[ADDR_W-1:0] : pt_off[ADDR_W-1:0];

	// flush: an entry written back last cycle reads stale, treat it as clean
	assign dirty_eff = dirty_rd_q && !(wb_vld_s2 && (wb_addr_s2 == flush_addr_s1));
	assign wb_en     = flush_vld_s1 && dirty_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_vld_s1 <= 1'b0;
			wb_vld_s2    <= 1'b0;
		end else begin
			flush_vld_s1 <= ctl.step && (cmd_q == CMD_FLUSH) && pix_ok;
			wb_vld_s2    <= wb_en;
		end
	end

	always_ff @(posedge clk) begin
		flush_addr_s1 <= walk_off[ADDR_W-1:0];
		wb_addr_s2    <= flush_addr_s1;
	end

	// write port selection
	always_comb begin
		shadow_we = 1'b0;
		shadow_wa = walk_off[ADDR_W-1:0];
		dirty_we  = 1'b0;
		dirty_wa  = walk_off[ADDR_W-1:0];
		dirty_wd  = 1'b1;
		shown_we  = 1'b0;
		shown_wa  = flush_addr_s1;
		shown_wd  = shadow_rd_q;
		if (ctl.clear) begin
			dirty_we = 1'b1;
			dirty_wa = clr_q;
			dirty_wd = 1'b0;
			shown_we = 1'b1;
			shown_wa = clr_q;
			shown_wd = '0;
		end else if (ctl.point) begin
			if (cmd_q == CMD_POINT && pt_in_range) begin
				shadow_we = 1'b1;
				shadow_wa = pt_off[ADDR_W-1:0];
				dirty_we  = 1'b1;
				dirty_wa  = pt_off[ADDR_W-1:0];
			end
		end else if (ctl.step && cmd_q == CMD_FILL && pix_ok) begin
			shadow_we = 1'b1;
			dirty_we  = 1'b1;
		end else if (wb_en) begin
			dirty_we = 1'b1;
			dirty_wa = flush_addr_s1;
			dirty_wd = 1'b0;
			shown_we = 1'b1;
		end
	end

	// shadow store
	always_ff @(posedge clk) begin
		if (shadow_we) begin
			shadow_mem[shadow_wa] <= color_q;
		end
		shadow_rd_q <= shadow_mem[rd_addr];
	end

	// dirty map
	always_ff @(posedge clk) begin
		if (dirty_we) begin
			dirty_mem[dirty_wa] <= dirty_wd;
		end
		dirty_rd_q <= dirty_mem[rd_addr];
	end

	// displayed store
	always_ff @(posedge clk) begin
		if (shown_we) begin
			shown_mem[shown_wa] <= shown_wd;
		end
		shown_rd_q <= shown_mem[rd_addr];
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			pixel_value_q <= (cmd_q == CMD_READ && pt_in_range) ? shown_rd_q : '0;
			pixel_dirty_q <= (cmd_q == CMD_READ && pt_in_range) ? dirty_rd_q : 1'b0;
			status_q      <= (cmd_q == CMD_POINT) && !pt_in_range;
		end
	end

	assign pixel_value = pixel_value_q;
	assign pixel_dirty = pixel_dirty_q;
	assign status      = status_q;

endmodule

// ===== sv/dirty_tracked_framebuffer_unit.sv =====
// ----------------------------------------------------------------------------
// dirty_tracked_framebuffer_unit
// Shadow framebuffer with a per-pixel dirty map and a displayed store.
// ----------------------------------------------------------------------------
// Drawing (point write, rectangle fill) goes to the shadow store and marks
// pixels dirty; a rectangle flush copies dirty pixels to the displayed store
// and cleans them; a read returns a displayed pixel and its dirty bit. Every
// command gives exactly one output beat. After reset the block runs a
// clearing pass over all 4096 entries of the dirty map and displayed store,
// one entry per cycle, before it takes the first input beat. One command is
// worked at a time: a point write or read passes the point and done states
// before its output beat is registered; a fill or a flush goes through the
// single write port of each store, which the rectangle walker uses once per
// pixel (an empty rectangle counts as one), then the drain and done states.
// The next input beat is taken while the previous output beat still waits.
// ----------------------------------------------------------------------------
module dirty_tracked_framebuffer_unit
	import dtf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         cmd,
	input  logic [POS_W-1:0]   pos_x,
	input  logic [POS_W-1:0]   pos_y,
	input  logic [SIZE_W-1:0]  rect_width,
	input  logic [SIZE_W-1:0]  rect_height,
	input  logic [COLOR_W-1:0] color,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COLOR_W-1:0] pixel_value,
	output logic               pixel_dirty,
	output logic               status
);

	dtf_ctl_t  ctl;
	dtf_stat_t stat;
	cmd_t      cmd_in;

	assign cmd_in = cmd_t'(cmd);

	// controller
	dtf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd_in),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.stat      (stat),
		.ctl       (ctl)
	);

	// datapath
	dtf_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.stat        (stat),
		.cmd         (cmd_in),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.pixel_value (pixel_value),
		.pixel_dirty (pixel_dirty),
		.status      (status)
	);

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the dirty tracked framebuffer unit. A mirror of the
// shadow store, dirty map and displayed store predicts the reply of every
// accepted command beat. Each reply beat is compared field by field. Stimulus
// is a directed opening, then random drawing, flushing and reading that stays
// mostly in one corner of the screen, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;
	import dtf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// the run limit is well above the slowest correct run (clearing pass, about a
	// dozen rectangles of up to 127x127, small items, stalls, one long hold)
	localparam int CYCLE_LIMIT = 1000000;
	localparam int RANDOM_ITEMS = 140;
	localparam int LONG_HOLD = 400;

	typedef struct {
		logic [COLOR_W-1:0] value;
		logic               dirty;
		logic               flag;
	} pixel_reply_t;

	// mirror of the three stores, predicts one reply per command
	class framebuffer_mirror;
		logic [COLOR_W-1:0] shadow_px [PIXEL_COUNT];
		bit                 dirty_px [PIXEL_COUNT];
		logic [COLOR_W-1:0] shown_px [PIXEL_COUNT];
		pixel_reply_t       replies_due [$];
		int                 mismatches;

		function new();
			foreach (shadow_px[i]) begin
				shadow_px[i] = '0;
				dirty_px[i] = 1'b0;
				shown_px[i] = '0;
			end
			mismatches = 0;
		endfunction

		function void apply_command(cmd_t op, int x, int y, int w, int h,
				logic [COLOR_W-1:0] c);
			pixel_reply_t r;
			int off;
			r.value = '0;
			r.dirty = 1'b0;
			r.flag = 1'b0;
			case (op)
				CMD_POINT: begin
					off = x + SCREEN_WIDTH * y;
					if (off < PIXEL_COUNT) begin
						shadow_px[off] = c;
						dirty_px[off] = 1'b1;
					end else begin
						r.flag = 1'b1;
					end
				end
				CMD_FILL, CMD_FLUSH: begin
					// linear offset: columns past the edge spill into the next row
					for (int row = 0; row < h; row++) begin
						for (int col = 0; col < w; col++) begin
							off = (x + col) + SCREEN_WIDTH * (y + row);
							if (off < PIXEL_COUNT) begin
								if (op == CMD_FILL) begin
									shadow_px[off] = c;
									dirty_px[off] = 1'b1;
								end else if (dirty_px[off]) begin
									shown_px[off] = shadow_px[off];
									dirty_px[off] = 1'b0;
								end
							end
						end
					end
				end
				default: begin
					off = x + SCREEN_WIDTH * y;
					if (off < PIXEL_COUNT) begin
						r.value = shown_px[off];
						r.dirty = dirty_px[off];
					end
				end
			endcase
			replies_due.push_back(r);
		endfunction

		function void check_reply(logic [COLOR_W-1:0] value, logic dirty, logic flag);
			pixel_reply_t want;
			if (replies_due.size() == 0) begin
				$error("reply beat with nothing expected: pixel_value %h", value);
				mismatches++;
				return;
			end
			want = replies_due.pop_front();
			if (value !== want.value) begin
				$error("pixel_value: expected %h, got %h", want.value, value);
				mismatches++;
			end
			if (dirty !== want.dirty) begin
				$error("pixel_dirty: expected %b, got %b", want.dirty, dirty);
				mismatches++;
			end
			if (flag !== want.flag) begin
				$error("status: expected %b, got %b", want.flag, flag);
				mismatches++;
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         cmd;
	logic [POS_W-1:0]   pos_x;
	logic [POS_W-1:0]   pos_y;
	logic [SIZE_W-1:0]  rect_width;
	logic [SIZE_W-1:0]  rect_height;
	logic [COLOR_W-1:0] color;
	logic               out_valid;
	logic               out_ready;
	logic [COLOR_W-1:0] pixel_value;
	logic               pixel_dirty;
	logic               status;

	framebuffer_mirror fb_mirror;
	bit                hold_burst = 1'b0;
	bit                steady = 1'b0;
	int                cycles = 0;

	dirty_tracked_framebuffer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.color       (color),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.pixel_value (pixel_value),
		.pixel_dirty (pixel_dirty),
		.status      (status)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// reply beat check
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			fb_mirror.check_reply(pixel_value, pixel_dirty, status);
	end

	// reply side: random stall per beat, one long hold on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_burst) begin
				stall = LONG_HOLD;
				hold_burst = 1'b0;
			end else if (steady) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 9);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// one command beat, entered and left at a falling edge
	task automatic send_command(input cmd_t op, input int x, input int y, input int w,
			input int h, input logic [COLOR_W-1:0] c);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pos_x <= POS_W'(x);
		pos_y <= POS_W'(y);
		rect_width <= SIZE_W'(w);
		rect_height <= SIZE_W'(h);
		color <= c;
		do @(posedge clk); while (!in_ready);
		fb_mirror.apply_command(op, x, y, w, h, c);
		@(negedge clk);
	endtask

	// stop offering and let every reply come back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (fb_mirror.replies_due.size() != 0) @(negedge clk);
		@(negedge clk);
	endtask

	task automatic random_command(input int idx);
		cmd_t op;
		int x, y, w, h, pick;
		logic [COLOR_W-1:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 30)
			op = CMD_POINT;
		else if (pick < 55)
			op = CMD_FILL;
		else if (pick < 75)
			op = CMD_FLUSH;
		else
			op = CMD_READ;
		// mostly a small corner, so reads land on drawn and flushed pixels
		if ($urandom_range(0, 3) != 0) begin
			x = $urandom_range(0, 15);
			y = $urandom_range(0, 15);
		end else begin
			x = $urandom_range(0, 63);
			y = $urandom_range(0, 63);
		end
		// rare big rectangles, occasional empty ones, mostly small
		if (idx % 20 == 19) begin
			w = $urandom_range(32, 127);
			h = $urandom_range(32, 127);
		end else if ($urandom_range(0, 15) == 0) begin
			w = $urandom_range(0, 1);
			h = $urandom_range(0, 1);
		end else begin
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 12);
		end
		c = COLOR_W'($urandom);
		send_command(op, x, y, w, h, c);
	endtask

	initial begin
		fb_mirror = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = CMD_POINT;
		pos_x = '0;
		pos_y = '0;
		rect_width = '0;
		rect_height = '0;
		color = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: corners, color extremes, edge spill, clipping, empty rects
		send_command(CMD_READ, 0, 0, 0, 0, 16'h0000);
		send_command(CMD_POINT, 0, 0, 0, 0, 16'hFFFF);
		send_command(CMD_READ, 0, 0, 0, 0, 16'h0000);
		send_command(CMD_POINT, 63, 63, 127, 127, 16'h0000);
		send_command(CMD_FILL, 60, 2, 10, 3, 16'h1234);
		send_command(CMD_FILL, 0, 62, 4, 5, 16'h5A5A);
		send_command(CMD_FILL, 8, 8, 0, 5, 16'hBEEF);
		send_command(CMD_FILL, 8, 8, 3, 0, 16'hBEEF);
		send_command(CMD_READ, 62, 2, 0, 0, 16'h0000);
		send_command(CMD_FLUSH, 60, 2, 10, 3, 16'h0000);
		send_command(CMD_READ, 62, 2, 0, 0, 16'h0000);
		send_command(CMD_READ, 1, 3, 0, 0, 16'h0000);
		send_command(CMD_FLUSH, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 16'h0000);
		send_command(CMD_READ, 0, 0, 0, 0, 16'h0000);
		send_command(CMD_READ, 63, 63, 0, 0, 16'h0000);
		send_command(CMD_FILL, 0, 0, 127, 127, 16'hA5A5);
		send_command(CMD_FLUSH, 63, 63, 127, 127, 16'h0000);
		send_command(CMD_READ, 63, 63, 0, 0, 16'h0000);
		send_command(CMD_READ, 0, 0, 0, 0, 16'h0000);
		send_command(CMD_FLUSH, 0, 0, 0, 0, 16'h0000);
		send_command(CMD_FLUSH, 0, 0, SCREEN_WIDTH, SCREEN_HEIGHT, 16'h0000);
		send_command(CMD_READ, 32, 32, 0, 0, 16'h0000);
		send_command(CMD_READ, 0, 63, 0, 0, 16'h0000);

		// random traffic with a long reply hold, a drain and a no-idle stretch
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == 40)
				hold_burst = 1'b1;
			if (i == 80)
				wait_idle();
			if (i == 100)
				steady = 1'b1;
			if (i == 120)
				steady = 1'b0;
			random_command(i);
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (fb_mirror.mismatches == 0 && fb_mirror.replies_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
